FILE: hdl/prf_pkg.sv
`timescale 1ns / 1ps

package prf_pkg;

    localparam int CoordW      = 24;
    localparam int DiffW       = CoordW + 1;
    localparam int SqW         = 2 * DiffW;
    localparam int SumW        = SqW + 2;
    localparam int MagW        = 14;
    localparam int R2W         = 28;
    localparam int GainW       = 32;
    localparam int LimitW      = 31;
    localparam int QuoW        = 31;
    localparam int RootW       = 22;
    localparam int SqrtXW      = 2 * RootW;
    localparam int SqrtRemW    = RootW + 3;
    localparam int ProdW       = MagW + LimitW;
    localparam int PushW       = 32;
    localparam int StepsPerStg = 4;
    localparam int AStages     = 8;
    localparam int BStages     = 8;

    localparam logic [SumW-1:0] EpsQ16    = SumW'(655);
    localparam logic [SumW-1:0] CutoffQ16 = SumW'(235929600);
    localparam logic [GainW-1:0] GainReset   = GainW'(65536);
    localparam logic [LimitW-1:0] LimitReset = LimitW'(655360);
    localparam logic [QuoW-1:0] SatMax = {QuoW{1'b1}};

    typedef enum logic
    {
        REG_GAIN  = 1'b0,
        REG_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic                        valid;
        logic [2:0][DiffW-1:0]       d;
    } stage_d_t;

    typedef struct packed
    {
        logic                        valid;
        logic [2:0]                  neg;
        logic [2:0][DiffW-1:0]       mag;
        logic [2:0][SqW-1:0]         sq;
    } stage_sq_t;

    typedef struct packed
    {
        logic                        valid;
        logic                        in_range;
        logic [2:0]                  neg;
        logic [2:0][MagW-1:0]        mag;
        logic [R2W-1:0]              r2;
    } stage_r2_t;

    typedef struct packed
    {
        logic                        valid;
        logic                        in_range;
        logic [2:0]                  neg;
        logic [2:0][MagW-1:0]        mag;
        logic [R2W-1:0]              r2;
        logic                        f_sat;
        logic [R2W-1:0]              f_rem;
        logic [QuoW-1:0]             f_quo;
        logic [QuoW-1:0]             f_low;
        logic [SqrtXW-1:0]           s_x;
        logic [SqrtRemW-1:0]         s_rem;
        logic [RootW-1:0]            s_root;
    } stage_a_t;

    typedef struct packed
    {
        logic                        valid;
        logic                        in_range;
        logic [2:0]                  neg;
        logic [RootW-1:0]            rq;
        logic [2:0][ProdW-1:0]       prod;
    } stage_m_t;

    typedef struct packed
    {
        logic                        valid;
        logic                        in_range;
        logic [2:0]                  neg;
        logic [RootW-1:0]            rq;
        logic [2:0]                  sat;
        logic [2:0][RootW-1:0]       rem;
        logic [2:0][QuoW-1:0]        quo;
        logic [2:0][QuoW-1:0]        low;
    } stage_b_t;

    typedef struct packed
    {
        logic                        valid;
        logic                        in_range;
        logic [2:0][PushW-1:0]       push;
    } stage_o_t;

endpackage

FILE: hdl/pairwise_repulsion_force.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_ready       first_x/y/z, second_x/y/z
// out      output     out_valid / out_ready     push_x/y/z, in_range
// cfg      input      cfg_write                 cfg_index, cfg_data
//
// One item is accepted per cycle unless the output stalls; items pass d, sq, r2,
// a, m, b, o stages; a and b hold the 31-step dividers, 4 steps/stage, 8 stages each.
// All stages advance together; a stall at the output holds every stage in place.
// Reset clears all valid bits and loads the default gain and force limit.

module pairwise_repulsion_force
    import prf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [GainW-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] first_x,
    input  logic signed [CoordW-1:0] first_y,
    input  logic signed [CoordW-1:0] first_z,
    input  logic signed [CoordW-1:0] second_x,
    input  logic signed [CoordW-1:0] second_y,
    input  logic signed [CoordW-1:0] second_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PushW-1:0]  push_x,
    output logic signed [PushW-1:0]  push_y,
    output logic signed [PushW-1:0]  push_z,
    output logic                     in_range
);

    logic [GainW-1:0]  gain_reg;
    logic [LimitW-1:0] limit_reg;

    stage_d_t  d_reg,  d_next;
    stage_sq_t sq_reg, sq_next;
    stage_r2_t r2_reg, r2_next;
    stage_a_t  a_reg  [AStages];
    stage_a_t  a_next [AStages];
    stage_m_t  m_reg,  m_next;
    stage_b_t  b_reg  [BStages];
    stage_b_t  b_next [BStages];
    stage_o_t  o_reg,  o_next;

    logic advance;

    assign advance  = !o_reg.valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GainReset;
            limit_reg <= LimitReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data[LimitW-1:0];
                default:   gain_reg  <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        d_next.valid = in_valid;
        d_next.d[0]  = DiffW'(first_x)  - DiffW'(second_x);
        d_next.d[1]  = DiffW'(first_y)  - DiffW'(second_y);
        d_next.d[2]  = DiffW'(first_z)  - DiffW'(second_z);
    end

    always_comb
    begin
        sq_next.valid = d_reg.valid;
        for (int i = 0; i < 3; i++)
        begin
            sq_next.neg[i] = d_reg.d[i][DiffW-1];
            sq_next.mag[i] = d_reg.d[i][DiffW-1] ? (~d_reg.d[i] + 1'b1) : d_reg.d[i];
            sq_next.sq[i]  = sq_next.mag[i] * sq_next.mag[i];
        end
    end

    always_comb
    begin
        logic [SumW-1:0] sum;
        sum = SumW'(sq_reg.sq[0]) + SumW'(sq_reg.sq[1]) + SumW'(sq_reg.sq[2]) + EpsQ16;
        r2_next.valid    = sq_reg.valid;
        r2_next.in_range = (sum <= CutoffQ16);
        r2_next.neg      = sq_reg.neg;
        r2_next.r2       = r2_next.in_range ? sum[R2W-1:0] : CutoffQ16[R2W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            r2_next.mag[i] = r2_next.in_range ? sq_reg.mag[i][MagW-1:0] : '0;
        end
    end

    always_comb
    begin
        stage_a_t          cur;
        logic [R2W:0]      frem;
        logic [SqrtRemW-1:0] srem;
        logic [SqrtRemW-1:0] trial;
        int                idx;
        for (int j = 0; j < AStages; j++)
        begin
            if (j == 0)
            begin
                cur.valid    = r2_reg.valid;
                cur.in_range = r2_reg.in_range;
                cur.neg      = r2_reg.neg;
                cur.mag      = r2_reg.mag;
                cur.r2       = r2_reg.r2;
                cur.f_sat    = R2W'(gain_reg[GainW-1:QuoW-16]) >= r2_reg.r2;
                cur.f_rem    = R2W'(gain_reg[GainW-1:QuoW-16]);
                cur.f_quo    = '0;
                cur.f_low    = {gain_reg[QuoW-17:0], 16'b0};
                cur.s_x      = {r2_reg.r2, 16'b0};
                cur.s_rem    = '0;
                cur.s_root   = '0;
            end
            else
            begin
                cur = a_reg[j-1];
            end
            for (int k = 0; k < StepsPerStg; k++)
            begin
                idx = j * StepsPerStg + k;
                if (idx < QuoW)
                begin
                    frem      = {cur.f_rem, cur.f_low[QuoW-1]};
                    cur.f_low = {cur.f_low[QuoW-2:0], 1'b0};
                    if (frem >= {1'b0, cur.r2})
                    begin
                        frem      = frem - {1'b0, cur.r2};
                        cur.f_quo = {cur.f_quo[QuoW-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.f_quo = {cur.f_quo[QuoW-2:0], 1'b0};
                    end
                    cur.f_rem = frem[R2W-1:0];
                end
                if (idx < RootW)
                begin
                    srem    = {cur.s_rem[SqrtRemW-3:0], cur.s_x[SqrtXW-1:SqrtXW-2]};
                    cur.s_x = {cur.s_x[SqrtXW-3:0], 2'b00};
                    trial   = SqrtRemW'({cur.s_root, 2'b01});
                    if (srem >= trial)
                    begin
                        srem       = srem - trial;
                        cur.s_root = {cur.s_root[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.s_root = {cur.s_root[RootW-2:0], 1'b0};
                    end
                    cur.s_rem = srem;
                end
            end
            a_next[j] = cur;
        end
    end

    always_comb
    begin
        logic [LimitW-1:0] f;
        stage_a_t          last;
        last = a_reg[AStages-1];
        if (last.f_sat || (last.f_quo > limit_reg))
        begin
            f = limit_reg;
        end
        else
        begin
            f = last.f_quo;
        end
        m_next.valid    = last.valid;
        m_next.in_range = last.in_range;
        m_next.neg      = last.neg;
        m_next.rq       = last.s_root;
        for (int i = 0; i < 3; i++)
        begin
            m_next.prod[i] = ProdW'(last.mag[i]) * ProdW'(f);
        end
    end

    always_comb
    begin
        stage_b_t       cur;
        logic [RootW:0] brem;
        int             idx;
        for (int j = 0; j < BStages; j++)
        begin
            if (j == 0)
            begin
                cur.valid    = m_reg.valid;
                cur.in_range = m_reg.in_range;
                cur.neg      = m_reg.neg;
                cur.rq       = m_reg.rq;
                for (int i = 0; i < 3; i++)
                begin
                    cur.sat[i] = m_reg.prod[i][ProdW-1:ProdW-RootW] >= m_reg.rq;
                    cur.rem[i] = m_reg.prod[i][ProdW-1:ProdW-RootW];
                    cur.quo[i] = '0;
                    cur.low[i] = {m_reg.prod[i][ProdW-RootW-1:0], 8'b0};
                end
            end
            else
            begin
                cur = b_reg[j-1];
            end
            for (int k = 0; k < StepsPerStg; k++)
            begin
                idx = j * StepsPerStg + k;
                if (idx < QuoW)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        brem       = {cur.rem[i], cur.low[i][QuoW-1]};
                        cur.low[i] = {cur.low[i][QuoW-2:0], 1'b0};
                        if (brem >= {1'b0, cur.rq})
                        begin
                            brem       = brem - {1'b0, cur.rq};
                            cur.quo[i] = {cur.quo[i][QuoW-2:0], 1'b1};
                        end
                        else
                        begin
                            cur.quo[i] = {cur.quo[i][QuoW-2:0], 1'b0};
                        end
                        cur.rem[i] = brem[RootW-1:0];
                    end
                end
            end
            b_next[j] = cur;
        end
    end

    always_comb
    begin
        logic [QuoW-1:0] c;
        stage_b_t        last;
        last = b_reg[BStages-1];
        o_next.valid    = last.valid;
        o_next.in_range = last.in_range;
        for (int i = 0; i < 3; i++)
        begin
            c = last.sat[i] ? SatMax : last.quo[i];
            o_next.push[i] = last.neg[i] ? (~{1'b0, c} + 1'b1) : {1'b0, c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg  <= '0;
            sq_reg <= '0;
            r2_reg <= '0;
            m_reg  <= '0;
            o_reg  <= '0;
            for (int j = 0; j < AStages; j++)
            begin
                a_reg[j] <= '0;
            end
            for (int j = 0; j < BStages; j++)
            begin
                b_reg[j] <= '0;
            end
        end
        else if (advance)
        begin
            d_reg  <= d_next;
            sq_reg <= sq_next;
            r2_reg <= r2_next;
            m_reg  <= m_next;
            o_reg  <= o_next;
            for (int j = 0; j < AStages; j++)
            begin
                a_reg[j] <= a_next[j];
            end
            for (int j = 0; j < BStages; j++)
            begin
                b_reg[j] <= b_next[j];
            end
        end
    end

    assign out_valid = o_reg.valid;
    assign in_range  = o_reg.in_range;
    assign push_x    = o_reg.push[0];
    assign push_y    = o_reg.push[1];
    assign push_z    = o_reg.push[2];

endmodule

FILE: verif/pairwise_repulsion_force_tb.sv
`timescale 1ns / 1ps

module pairwise_repulsion_force_tb
    import prf_pkg::*;
();

    typedef struct {
        logic signed [PushW-1:0] fx;
        logic signed [PushW-1:0] fy;
        logic signed [PushW-1:0] fz;
        logic                    near;
    } push_t;

    class push_scoreboard;
        logic [31:0] gain;
        logic [30:0] limit;
        push_t       pending[$];
        int          errors;

        function new();
            gain = GainReset;
            limit = LimitReset;
            errors = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] root;
            logic [63:0] trial;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x)
                    root = trial;
            end
            return root;
        endfunction

        function void note_pair(logic signed [23:0] a[3], logic signed [23:0] b[3]);
            logic signed [63:0] d[3];
            logic [63:0] m[3];
            logic [63:0] r2;
            logic [63:0] f;
            logic [63:0] rq;
            logic [63:0] c;
            logic [31:0] p[3];
            push_t e;
            r2 = 655;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = 64'(a[i]) - 64'(b[i]);
                m[i] = d[i] < 0 ? -d[i] : d[i];
                r2 += m[i] * m[i];
            end
            if (r2 > 64'd235929600)
            begin
                e.fx = 0;
                e.fy = 0;
                e.fz = 0;
                e.near = 0;
            end
            else
            begin
                f = {16'd0, gain, 16'd0} / r2;
                if (f > limit)
                    f = limit;
                rq = int_sqrt(r2 << 16);
                for (int i = 0; i < 3; i++)
                begin
                    c = (m[i] * f * 256) / rq;
                    if (c > 64'd2147483647)
                        c = 64'd2147483647;
                    p[i] = d[i] < 0 ? 32'(-c) : 32'(c);
                end
                e.fx = p[0];
                e.fy = p[1];
                e.fz = p[2];
                e.near = 1;
            end
            pending.push_back(e);
        endfunction

        function void check_push(push_t got);
            push_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.fx !== e.fx)
            begin
                $error("push_x expected %0d actual %0d", e.fx, got.fx);
                errors++;
            end
            if (got.fy !== e.fy)
            begin
                $error("push_y expected %0d actual %0d", e.fy, got.fy);
                errors++;
            end
            if (got.fz !== e.fz)
            begin
                $error("push_z expected %0d actual %0d", e.fz, got.fz);
                errors++;
            end
            if (got.near !== e.near)
            begin
                $error("in_range expected %0d actual %0d", e.near, got.near);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic [GainW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [CoordW-1:0] first_x, first_y, first_z;
    logic signed [CoordW-1:0] second_x, second_y, second_z;
    logic out_valid;
    logic out_ready;
    logic signed [PushW-1:0] push_x, push_y, push_z;
    logic in_range;

    push_scoreboard sb;
    longint cycles;

    pairwise_repulsion_force dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        push_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.fx = push_x;
            got.fy = push_y;
            got.fz = push_z;
            got.near = in_range;
            sb.check_push(got);
        end
    end

    initial
    begin
        out_ready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                out_ready = 0;
            else if ($urandom_range(0, 1) == 0)
                out_ready = ($urandom_range(0, 10) == 0);
            else
                out_ready = 1;
            if (!out_ready)
                repeat ($urandom_range(0, 10)) @(negedge clk);
            out_ready = 1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_write = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 0;
        if (idx == REG_GAIN)
            sb.gain = val;
        else
            sb.limit = val[30:0];
    endtask

    task automatic send_pair(logic signed [23:0] a[3], logic signed [23:0] b[3],
                             bit no_gap);
        if (!no_gap)
            repeat ($urandom_range(0, 10)) @(negedge clk);
        first_x = a[0];
        first_y = a[1];
        first_z = a[2];
        second_x = b[0];
        second_y = b[1];
        second_z = b[2];
        in_valid = 1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pair(a, b);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic wait_drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic random_pair(bit no_gap);
        logic signed [23:0] a[3];
        logic signed [23:0] b[3];
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 24'($urandom);
            if (mode < 5)
                b[i] = a[i] + 24'($signed($urandom_range(0, 2 * 6000) - 6000));
            else if (mode < 8)
                b[i] = a[i] + 24'($signed($urandom_range(0, 2 * 200) - 200));
            else
                b[i] = 24'($urandom);
        end
        send_pair(a, b, no_gap);
    endtask

    initial
    begin
        logic signed [23:0] a[3];
        logic signed [23:0] b[3];
        logic [31:0] gains[5];
        logic [31:0] limits[5];
        sb = new();
        cycles = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = REG_GAIN;
        cfg_data = 0;
        in_valid = 0;
        {first_x, first_y, first_z, second_x, second_y, second_z} = '0;
        repeat (9) @(negedge clk);
        rst_n = 1;

        a = '{0, 0, 0}; b = '{0, 0, 0}; send_pair(a, b, 0);
        a = '{24'h7fffff, 24'h7fffff, 24'h7fffff};
        b = '{24'h800000, 24'h800000, 24'h800000}; send_pair(a, b, 0);
        send_pair(b, a, 0);
        a = '{256, 0, 0}; b = '{0, 0, 0}; send_pair(a, b, 0);
        a = '{0, -256, 0}; send_pair(a, b, 0);
        a = '{0, 0, 1}; send_pair(a, b, 0);
        a = '{15360, 0, 0}; send_pair(a, b, 0);
        a = '{15361, 0, 0}; send_pair(a, b, 0);
        a = '{-1, 1, -1}; send_pair(a, b, 0);
        a = '{24'h800000, 0, 0}; b = '{24'h7fc500, 0, 0}; send_pair(a, b, 0);
        wait_drain();
        write_reg(REG_GAIN, 32'hffffffff);
        write_reg(REG_LIMIT, 32'hffffffff);
        a = '{1, 0, 0}; b = '{0, 0, 0}; send_pair(a, b, 0);
        a = '{0, 1, -1}; send_pair(a, b, 0);
        a = '{-1, -1, -1}; send_pair(a, b, 0);
        a = '{0, 0, 0}; send_pair(a, b, 0);
        wait_drain();

        gains = '{32'd0, 32'd65536, 32'hffffffff, 32'd100000000, 32'd0};
        limits = '{32'd0, 32'd655360, 32'h7fffffff, 32'hffffffff, 32'd12345};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 5)
            begin
                write_reg(REG_GAIN, ph == 4 ? $urandom : gains[ph]);
                write_reg(REG_LIMIT, ph == 4 ? $urandom : limits[ph]);
            end
            else
            begin
                write_reg(REG_GAIN, GainReset);
                write_reg(REG_LIMIT, 32'(LimitReset));
            end
            for (int n = 0; n < 150; n++)
                random_pair(n % 50 > 30);
            wait_drain();
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/prf_pkg.sv
hdl/pairwise_repulsion_force.sv
verif/pairwise_repulsion_force_tb.sv
